@@ hw/rtl/ors_pkg.sv @@
// Package for the 1-Wire ROM search engine: transaction types, command,
// status and phase codes, and ROM size constants.
// No dependencies.
package ors_pkg;

    // ROM length in bytes (1 to 8) and the resulting bit count.
    localparam int ROM_BYTES = 8;
    localparam int ROM_BITS  = 8 * ROM_BYTES;

    // Last bit position that still lies in the family byte.
    localparam logic [6:0] FAMILY_LAST_POS = 7'd8;

    // Search command byte the host sends after a ready status.
    localparam logic [7:0] SEARCH_ROM_CMD = 8'hF0;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_START = 2'd0;
    localparam cmd_t CMD_RESET = 2'd1;
    localparam cmd_t CMD_PAIR  = 2'd2;

    typedef enum logic [2:0] {
        ST_READY   = 3'd0,
        ST_DIR     = 3'd1,
        ST_MORE    = 3'd2,
        ST_LAST    = 3'd3,
        ST_END     = 3'd4,
        ST_IGNORED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_RESET = 2'd1,
        PH_SEARCH     = 2'd2
    } phase_t;

    typedef struct packed {
        cmd_t cmd;
        logic presence;
        logic id_bit;
        logic complement_bit;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        direction_valid;
        logic        direction;
        logic [63:0] rom_code;
        logic [7:0]  device_count;
        logic [3:0]  family_discrepancy;
    } result_t;

endpackage

@@ hw/rtl/ors_engine.sv @@
// Search state and combinational step logic of the 1-Wire ROM search.
// Depends on ors_pkg.
module ors_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ors_pkg::item_t   item,
    output ors_pkg::result_t result
);
    import ors_pkg::*;

    localparam logic [6:0] TOTAL_BITS = 7'(ROM_BITS);

    logic [63:0] rom_reg, rom_next;
    logic [6:0]  bit_pos_reg, bit_pos_next;
    logic [6:0]  last_zero_reg, last_zero_next;
    logic [6:0]  last_disc_reg, last_disc_next;
    logic [3:0]  family_disc_reg, family_disc_next;
    logic [7:0]  found_reg, found_next;
    phase_t      phase_reg, phase_next;

    logic [5:0]  idx;
    logic [63:0] mask;
    logic [63:0] rom_upd;
    logic [6:0]  pos_inc;
    logic [6:0]  zero_upd;
    logic [3:0]  family_upd;
    logic        dir;

    // State registers; they advance only on a step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg         <= '0;
            bit_pos_reg     <= 7'd1;
            last_zero_reg   <= '0;
            last_disc_reg   <= '0;
            family_disc_reg <= '0;
            found_reg       <= '0;
            phase_reg       <= PH_IDLE;
        end
        else if (step)
        begin
            rom_reg         <= rom_next;
            bit_pos_reg     <= bit_pos_next;
            last_zero_reg   <= last_zero_next;
            last_disc_reg   <= last_disc_next;
            family_disc_reg <= family_disc_next;
            found_reg       <= found_next;
            phase_reg       <= phase_next;
        end
    end

    // Direction choice for the current bit pair.
    always_comb
    begin
        idx        = 6'(bit_pos_reg - 7'd1);
        mask       = 64'd1 << idx;
        zero_upd   = last_zero_reg;
        family_upd = family_disc_reg;
        if (item.id_bit != item.complement_bit)
        begin
            dir = item.id_bit;
        end
        else
        begin
            if (bit_pos_reg < last_disc_reg)
            begin
                dir = rom_reg[idx];
            end
            else
            begin
                dir = (bit_pos_reg == last_disc_reg);
            end
            if (!dir)
            begin
                zero_upd = bit_pos_reg;
                if (bit_pos_reg <= FAMILY_LAST_POS)
                begin
                    family_upd = bit_pos_reg[3:0];
                end
            end
        end
        rom_upd = dir ? (rom_reg | mask) : (rom_reg & ~mask);
        pos_inc = bit_pos_reg + 7'd1;
    end

    // Next state and result for one transaction.
    always_comb
    begin
        rom_next         = rom_reg;
        bit_pos_next     = bit_pos_reg;
        last_zero_next   = last_zero_reg;
        last_disc_next   = last_disc_reg;
        family_disc_next = family_disc_reg;
        found_next       = found_reg;
        phase_next       = phase_reg;

        result.status          = ST_IGNORED;
        result.direction_valid = 1'b0;
        result.direction       = 1'b0;

        priority if (item.cmd == CMD_START)
        begin
            rom_next         = '0;
            last_disc_next   = '0;
            family_disc_next = '0;
            found_next       = '0;
            bit_pos_next     = 7'd1;
            last_zero_next   = '0;
            phase_next       = PH_WAIT_RESET;
            result.status    = ST_READY;
        end
        else if (item.cmd == CMD_RESET)
        begin
            if (phase_reg == PH_WAIT_RESET)
            begin
                if (!item.presence)
                begin
                    phase_next    = PH_IDLE;
                    result.status = ST_END;
                end
                else
                begin
                    bit_pos_next   = 7'd1;
                    last_zero_next = '0;
                    phase_next     = PH_SEARCH;
                    result.status  = ST_READY;
                end
            end
        end
        else if (item.cmd == CMD_PAIR && phase_reg == PH_SEARCH)
        begin
            if (item.id_bit && item.complement_bit)
            begin
                // No device answered either value: the bus is empty or broken.
                phase_next    = PH_IDLE;
                result.status = ST_END;
            end
            else
            begin
                rom_next               = rom_upd;
                bit_pos_next           = pos_inc;
                last_zero_next         = zero_upd;
                family_disc_next       = family_upd;
                result.direction_valid = 1'b1;
                result.direction       = dir;
                if (pos_inc <= TOTAL_BITS)
                begin
                    result.status = ST_DIR;
                end
                else
                begin
                    // End of the pass: a zero family byte ends the enumeration.
                    last_disc_next = zero_upd;
                    if (rom_upd[7:0] == 8'd0)
                    begin
                        phase_next    = PH_IDLE;
                        result.status = ST_END;
                    end
                    else
                    begin
                        if (found_reg != 8'hFF)
                        begin
                            found_next = found_reg + 8'd1;
                        end
                        if (zero_upd == 7'd0)
                        begin
                            phase_next    = PH_IDLE;
                            result.status = ST_LAST;
                        end
                        else
                        begin
                            phase_next    = PH_WAIT_RESET;
                            result.status = ST_MORE;
                        end
                    end
                end
            end
        end
        else
        begin
            result.status = ST_IGNORED;
        end

        result.rom_code           = rom_next;
        result.device_count       = found_next;
        result.family_discrepancy = family_disc_next;
    end

endmodule

@@ hw/rtl/onewire_rom_search.sv @@
// Top level of the 1-Wire ROM search engine: input register, search
// engine and result register. Depends on ors_pkg and ors_engine.
//
// Usage: the host sends transactions on the item channel (item_valid,
// item_stall, item) and takes one result transaction per item on the
// result channel (result_valid, result_stall, result). A start command
// opens an enumeration; a ready status asks the host to send the search
// command 0xF0 after a bus reset, whose outcome comes back as a reset
// item. Each bit-pair item returns the direction bit to write back.
// After the last ROM bit the result carries the ROM code, the pass
// outcome and the running device count.
// The item passes through the input register and then the result register
// before result_valid rises; a stall on the result side can hold it in
// the input register. Throughput: one item per cycle while result_stall
// is low, set by the step of the engine state registers on each advance.
// Reset clears all search state, the phase becomes idle and both pipeline
// registers are empty. While the receiver stalls, the held result stays
// put, one more item may wait in the input register, and then item_stall
// rises until the result is taken.
module onewire_rom_search (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ors_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ors_pkg::result_t result
);
    import ors_pkg::*;

    logic    stage_valid_reg, stage_valid_next;
    item_t   stage_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t step_result;
    logic    advance;
    logic    take_in;

    // Handshake control of the two register stages.
    always_comb
    begin
        advance          = stage_valid_reg && !(out_valid_reg && result_stall);
        item_stall       = stage_valid_reg && !advance;
        take_in          = item_valid && !item_stall;
        stage_valid_next = take_in || (stage_valid_reg && !advance);
        out_valid_next   = advance || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_reg <= item;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    ors_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_reg),
        .result (step_result)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A step always leaves a result in the output register.
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("step did not load the result register");

    // The input side only stalls while both stages are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage_valid_reg && out_valid_reg && result_stall))
        else $error("item stall without full pipeline");

    // A direction status always comes with a direction to write.
    a_dir_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_DIR) |-> result.direction_valid)
        else $error("direction status without direction_valid");

    // Ready and ignored results never ask for a bus write.
    a_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == ST_READY || result.status == ST_IGNORED))
        |-> (!result.direction_valid && !result.direction))
        else $error("unexpected direction on ready or ignored result");

    // The family discrepancy never points past the family byte.
    a_family_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.family_discrepancy <= 4'd8))
        else $error("family discrepancy out of range");

endmodule
